// File: hdl/hhm_pkg.sv
// Shared types, codes and defaults for the heartbeat health monitor.
package hhm_pkg;

    localparam int NUM_SUBSYS_DEFAULT = 8;

    localparam int TICK_W   = 32;
    localparam int MISS_W   = 32;
    localparam int LIMIT_W  = 16;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 1;

    // Command codes
    localparam logic [1:0] CMD_ALIVE    = 2'd0;
    localparam logic [1:0] CMD_DEADLINE = 2'd1;
    localparam logic [1:0] CMD_CHECK    = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ALIVE_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MISS_LIMIT      = 1'd1;

    localparam logic [CFG_W-1:0]   ALIVE_THRESHOLD_RESET = '0;
    localparam logic [LIMIT_W-1:0] MISS_LIMIT_RESET      = 16'd3;

    typedef struct packed {
        logic [1:0]        command;
        logic [2:0]        subsystem;
        logic [TICK_W-1:0] tick_now;
        logic              deadline_met;
    } in_t;

    typedef struct packed {
        logic              subsys_alive;
        logic              all_alive;
        logic              timing_fault;
        logic              feed_watchdog;
        logic [MISS_W-1:0] miss_count;
    } out_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic update;
        logic scan_issue;
        logic load_out;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic issue_last;
    } dp_status_t;

endpackage

// File: hdl/hhm_datapath.sv
// Datapath: item register, last-seen table, miss counter, table scan and result register.
module hhm_datapath #(
    parameter int NUM_SUBSYS = hhm_pkg::NUM_SUBSYS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  hhm_pkg::in_t                      in_data,
    input  logic                              cfg_we,
    input  logic [hhm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [hhm_pkg::CFG_W-1:0]         cfg_data,
    input  hhm_pkg::dp_cmd_t                  cmd,
    output hhm_pkg::dp_status_t               status,
    output hhm_pkg::out_t                     out_data
);

    localparam int IDX_W = (NUM_SUBSYS > 1) ? $clog2(NUM_SUBSYS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SUBSYS - 1);

    hhm_pkg::in_t                     item_reg;
    logic [hhm_pkg::CFG_W-1:0]        thr_reg;
    logic [hhm_pkg::LIMIT_W-1:0]      limit_reg;
    logic [hhm_pkg::MISS_W-1:0]       miss_reg;
    logic [hhm_pkg::MISS_W-1:0]       miss_next;
    logic [NUM_SUBSYS-1:0]            seen_reg;
    logic [hhm_pkg::TICK_W-1:0]       mem [NUM_SUBSYS];
    logic [hhm_pkg::TICK_W-1:0]       rd_data_reg;
    logic [IDX_W-1:0]                 issue_reg;
    logic [IDX_W-1:0]                 rd_idx_reg;
    logic                             rd_valid_reg;
    logic                             all_reg;
    logic                             one_reg;
    logic                             sub_in_range;
    logic [IDX_W-1:0]                 wr_addr;
    logic                             alive_report;
    logic [hhm_pkg::TICK_W-1:0]       age;
    logic                             entry_alive;
    logic                             fault;
    hhm_pkg::out_t                    out_reg;
    hhm_pkg::out_t                    out_next;

    // Hold the accepted transaction
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= in_data;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg   <= hhm_pkg::ALIVE_THRESHOLD_RESET;
            limit_reg <= hhm_pkg::MISS_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                hhm_pkg::REG_ALIVE_THRESHOLD: thr_reg   <= cfg_data;
                hhm_pkg::REG_MISS_LIMIT:      limit_reg <= cfg_data[hhm_pkg::LIMIT_W-1:0];
                default:                      ;
            endcase
        end
    end

    assign sub_in_range = (32'(item_reg.subsystem) < NUM_SUBSYS);
    assign wr_addr      = IDX_W'(item_reg.subsystem);
    assign alive_report = (item_reg.command == hhm_pkg::CMD_ALIVE) && sub_in_range;

    // Advance the consecutive miss counter, saturating when full; a met deadline clears it
    always_comb
    begin
        miss_next = miss_reg;
        if (item_reg.command == hhm_pkg::CMD_DEADLINE)
        begin
            if (item_reg.deadline_met)
            begin
                miss_next = '0;
            end
            else if (miss_reg != '1)
            begin
                miss_next = miss_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            miss_reg <= '0;
            seen_reg <= '0;
        end
        else if (cmd.update)
        begin
            miss_reg <= miss_next;
            if (alive_report)
            begin
                seen_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // Last-seen table; the seen mark qualifies every entry
    always_ff @(posedge clk)
    begin
        if (cmd.update && alive_report)
        begin
            mem[wr_addr] <= item_reg.tick_now;
        end
        rd_data_reg <= mem[issue_reg];
        rd_idx_reg  <= issue_reg;
    end

    // Step the scan address, one entry a cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.scan_issue;
            if (cmd.update)
            begin
                issue_reg <= '0;
            end
            else if (cmd.scan_issue && (issue_reg != LAST_IDX))
            begin
                issue_reg <= issue_reg + 1'b1;
            end
        end
    end

    assign status.issue_last = (issue_reg == LAST_IDX);

    // Judge one entry against the item's tick
    assign age         = item_reg.tick_now - rd_data_reg;
    assign entry_alive = seen_reg[rd_idx_reg] && (age <= thr_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            all_reg <= 1'b1;
            one_reg <= 1'b0;
        end
        else if (rd_valid_reg)
        begin
            all_reg <= all_reg & entry_alive;
            if (32'(rd_idx_reg) == 32'(item_reg.subsystem))
            begin
                one_reg <= entry_alive;
            end
        end
    end

    // Form and hold the result
    assign fault = (miss_reg >= {{(hhm_pkg::MISS_W - hhm_pkg::LIMIT_W){1'b0}}, limit_reg});

    always_comb
    begin
        out_next.subsys_alive  = one_reg;
        out_next.all_alive     = all_reg;
        out_next.timing_fault  = fault;
        out_next.feed_watchdog = all_reg & ~fault;
        out_next.miss_count    = miss_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_reg <= out_next;
        end
    end

    assign out_data = out_reg;

endmodule

// File: hdl/hhm_ctrl.sv
// Controller: sequences update, table scan and result handoff for each transaction.
module hhm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    input  hhm_pkg::dp_status_t status,
    output hhm_pkg::dp_cmd_t    cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_UPDATE = 5'b00010,
        S_SCAN   = 5'b00100,
        S_DRAIN  = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    // Next state and datapath commands
    always_comb
    begin
        state_next     = state_reg;
        cmd.capture    = 1'b0;
        cmd.update     = 1'b0;
        cmd.scan_issue = 1'b0;
        cmd.load_out   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan_issue = 1'b1;
                if (status.issue_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold the result valid until taken
    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FINISH))
        else $error("result raised outside finish");

    a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && status.issue_last) |=> (state_reg == S_DRAIN))
        else $error("scan did not end at last entry");

    a_finish_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && out_free) |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("finish did not hand off result");
`endif

endmodule

// File: hdl/heartbeat_health_monitor.sv
// Sequence: after acceptance the controller steps through update, scan, drain and finish;
// out_valid rises when finish loads the result, and in_stall holds new input until then.
// The scan reads one entry per cycle through the last-seen table's single read port.
// A new transaction is accepted while the previous result waits to be taken.
// rst_n (async low) resets seen marks, miss counter, control and config; no clearing pass.
module heartbeat_health_monitor #(
    parameter int NUM_SUBSYS = hhm_pkg::NUM_SUBSYS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  hhm_pkg::in_t                  in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output hhm_pkg::out_t                 out_data,
    input  logic                          cfg_we,
    input  logic [hhm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hhm_pkg::CFG_W-1:0]     cfg_data
);

    hhm_pkg::dp_cmd_t    cmd;
    hhm_pkg::dp_status_t status;

    hhm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    hhm_datapath #(
        .NUM_SUBSYS (NUM_SUBSYS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_data  (out_data)
    );

endmodule
